/* rtl/core/assert_macros.svh */
// Assertion macros shared by the codec RTL.
// Bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define UPC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition that must never be true outside reset
`define UPC_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define UPC_ASSERT(lbl, clk, rst, prop, msg)
`define UPC_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

/* rtl/core/upc_pkg.sv */
// Types, constants and character-class functions of the URI percent codec.
// No dependencies.
package upc_pkg;

  localparam int MaxUnits = 12;
  localparam int CntW     = 4;

  // mode register bits
  localparam int ModeUriBit    = 0;
  localparam int ModeDecodeBit = 1;

  localparam logic [15:0] ChPercent  = 16'h0025;
  localparam logic [5:0]  HiSurTag   = 6'b110110;
  localparam logic [5:0]  LoSurTag   = 6'b110111;
  localparam logic [20:0] SuppBase   = 21'h010000;
  localparam logic [20:0] MaxCp      = 21'h10FFFF;
  localparam logic [20:0] MinThree   = 21'h000800;
  localparam logic [20:0] SurLo      = 21'h00D800;
  localparam logic [20:0] SurHi      = 21'h00DFFF;
  localparam logic [7:0]  LeadTwoLo  = 8'hC2;
  localparam logic [7:0]  LeadTwoHi  = 8'hDF;
  localparam logic [7:0]  LeadFourHi = 8'hF4;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_HI   = 6'b000010,
    PH_LO   = 6'b000100,
    PH_PCT  = 6'b001000,
    PH_CHI  = 6'b010000,
    PH_CLO  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [15:0] unit;
    logic        uv;
    logic        se;
    logic        mal;
  } res_t;

  function automatic logic is_unreserved(input logic [15:0] u);
    logic r;
    r = 1'b0;
    if (u >= 16'h0041 && u <= 16'h005A) r = 1'b1;
    if (u >= 16'h0061 && u <= 16'h007A) r = 1'b1;
    if (u >= 16'h0030 && u <= 16'h0039) r = 1'b1;
    if (u == 16'h002D || u == 16'h005F || u == 16'h002E || u == 16'h0021 ||
        u == 16'h007E || u == 16'h002A || u == 16'h0027 || u == 16'h0028 ||
        u == 16'h0029) r = 1'b1;
    return r;
  endfunction

  function automatic logic is_reserved(input logic [15:0] u);
    return u == 16'h003B || u == 16'h002F || u == 16'h003F || u == 16'h003A ||
           u == 16'h0040 || u == 16'h0026 || u == 16'h003D || u == 16'h002B ||
           u == 16'h0024 || u == 16'h002C || u == 16'h0023;
  endfunction

  // hex digit value of either case; bit 4 set when not a digit
  function automatic logic [4:0] hex_val(input logic [15:0] u);
    logic [4:0] v;
    v = 5'h10;
    if (u >= 16'h0030 && u <= 16'h0039) v = 5'(u - 16'h0030);
    if (u >= 16'h0041 && u <= 16'h0046) v = 5'(u - 16'h0037);
    if (u >= 16'h0061 && u <= 16'h0066) v = 5'(u - 16'h0057);
    return v;
  endfunction

  // uppercase hex character
  function automatic logic [7:0] hex_char(input logic [3:0] d);
    return (d < 4'd10) ? (8'h30 + {4'h0, d}) : (8'h37 + {4'h0, d});
  endfunction

endpackage

/* rtl/core/uri_percent_codec.sv */
// URI percent codec top level; depends on upc_pkg and assert_macros.svh.
// Streaming encoder/decoder for the four ECMAScript URI functions, selected by
// codec_mode (0 encodeURIComponent, 1 encodeURI, 2 decodeURIComponent,
// 3 decodeURI); writing the mode restarts the string. One UTF-16 code unit is
// taken per beat into an input register, converted in one pass into a result
// buffer of up to twelve units, and the buffer drains one result beat per
// cycle while out_ready is high. An input beat passes the input register and
// then the result buffer. Plain text streams at one unit per cycle while
// out_ready is high; an item that yields k results holds the result buffer
// until all k have drained (up to 12 for a four-byte UTF-8 sequence), and that
// drain port sets the sustained rate. A malformed string ends with one result
// flagged malformed and string_end, and its remaining units are dropped.
`include "assert_macros.svh"

module uri_percent_codec (
  input  logic        clk,
  input  logic        rst,
  input  logic        codec_mode_wr_en,
  input  logic [1:0]  codec_mode_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] code_unit,
  input  logic        last_unit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_unit,
  output logic        unit_valid,
  output logic        string_end,
  output logic        malformed
);
  import upc_pkg::*;

  // registers
  logic [1:0]      mode;
  logic            s1_valid;
  logic [15:0]     s1_unit;
  logic            s1_last;
  logic [9:0]      held_high, held_high_next;
  logic            high_pending, high_pending_next;
  phase_t          phase, phase_next;
  logic [7:0]      first_hex, first_hex_next;
  logic [20:0]     accum, accum_next;
  logic [1:0]      remaining, remaining_next;
  logic [1:0]      seq_len, seq_len_next;
  logic            discarding, discarding_next;
  res_t            rbuf [MaxUnits];
  logic [CntW-1:0] rcnt;

  // combinational
  logic            buf_free;
  logic            s1_adv;
  logic            out_fire;
  logic            fail;
  logic            clear_st;
  logic [CntW-1:0] n_units;
  logic [15:0]     units [MaxUnits];
  res_t            res [MaxUnits];
  logic [CntW-1:0] res_n;
  logic            enc_go;
  logic [20:0]     enc_cp;
  logic [3:0][7:0] ubytes;
  logic [2:0]      unb;
  logic [4:0]      hv_u, hv_f;
  logic [7:0]      dbyte;
  logic [20:0]     cont_acc;
  logic [1:0]      rem_dec;
  logic [1:0]      lead_len;
  logic [19:0]     supp;

  // handshake
  assign out_fire = out_valid && out_ready;
  assign buf_free = (rcnt == '0) || (rcnt == CntW'(1) && out_ready);
  assign s1_adv   = s1_valid && buf_free;
  assign in_ready = !s1_valid || buf_free;

  assign out_valid  = rcnt != '0;
  assign out_unit   = rbuf[0].unit;
  assign unit_valid = rbuf[0].uv;
  assign string_end = rbuf[0].se;
  assign malformed  = rbuf[0].mal;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_unit <= code_unit;
      s1_last <= last_unit;
    end
  end

  // convert one unit: next string state and result list
  always_comb begin
    held_high_next    = held_high;
    high_pending_next = high_pending;
    phase_next        = phase;
    first_hex_next    = first_hex;
    accum_next        = accum;
    remaining_next    = remaining;
    seq_len_next      = seq_len;
    discarding_next   = discarding;
    fail     = 1'b0;
    n_units  = '0;
    enc_go   = 1'b0;
    enc_cp   = '0;
    lead_len = 2'd0;
    ubytes   = '0;
    unb      = 3'd0;
    for (int k = 0; k < MaxUnits; k++) begin
      units[k] = '0;
      res[k]   = '0;
    end
    hv_u     = hex_val(s1_unit);
    hv_f     = hex_val({8'h00, first_hex});
    dbyte    = {hv_f[3:0], hv_u[3:0]};
    cont_acc = {accum[14:0], dbyte[5:0]};
    rem_dec  = remaining - 2'd1;
    supp     = 20'(cont_acc - SuppBase);

    if (discarding) begin
      // drop units until the string ends
    end else if (!mode[ModeDecodeBit]) begin
      // encode
      if (high_pending) begin
        if (s1_unit[15:10] != LoSurTag) begin
          fail = 1'b1;
        end else begin
          high_pending_next = 1'b0;
          enc_go = 1'b1;
          enc_cp = SuppBase + {1'b0, held_high, s1_unit[9:0]};
        end
      end else if (is_unreserved(s1_unit) || (mode[ModeUriBit] && is_reserved(s1_unit))) begin
        units[0] = s1_unit;
        n_units  = CntW'(1);
      end else if (s1_unit[15:10] == HiSurTag) begin
        if (s1_last) begin
          fail = 1'b1;
        end else begin
          held_high_next    = s1_unit[9:0];
          high_pending_next = 1'b1;
        end
      end else if (s1_unit[15:10] == LoSurTag) begin
        fail = 1'b1;
      end else begin
        enc_go = 1'b1;
        enc_cp = {5'd0, s1_unit};
      end
    end else begin
      // decode
      case (phase)
        PH_IDLE: begin
          if (s1_unit != ChPercent) begin
            units[0] = s1_unit;
            n_units  = CntW'(1);
          end else if (s1_last) begin
            fail = 1'b1;
          end else begin
            phase_next = PH_HI;
          end
        end
        PH_HI, PH_CHI: begin
          if (hv_u[4] || s1_last) begin
            fail = 1'b1;
          end else begin
            first_hex_next = s1_unit[7:0];
            phase_next     = (phase == PH_HI) ? PH_LO : PH_CLO;
          end
        end
        PH_LO: begin
          if (hv_u[4]) begin
            fail = 1'b1;
          end else if (!dbyte[7]) begin
            if (mode[ModeUriBit] && is_reserved({8'h00, dbyte})) begin
              units[0] = ChPercent;
              units[1] = {8'h00, first_hex};
              units[2] = s1_unit;
              n_units  = CntW'(3);
            end else begin
              units[0] = {8'h00, dbyte};
              n_units  = CntW'(1);
            end
            phase_next = PH_IDLE;
          end else begin
            // classify the lead byte
            if (dbyte >= LeadTwoLo && dbyte <= LeadTwoHi) begin
              lead_len   = 2'd1;
              accum_next = {16'd0, dbyte[4:0]};
            end else if (dbyte[7:4] == 4'hE) begin
              lead_len   = 2'd2;
              accum_next = {17'd0, dbyte[3:0]};
            end else if (dbyte[7:4] == 4'hF && dbyte <= LeadFourHi) begin
              lead_len   = 2'd3;
              accum_next = {18'd0, dbyte[2:0]};
            end
            if (lead_len == 2'd0 || s1_last) begin
              fail = 1'b1;
            end else begin
              seq_len_next   = lead_len;
              remaining_next = lead_len;
              phase_next     = PH_PCT;
            end
          end
        end
        PH_PCT: begin
          if (s1_unit != ChPercent || s1_last) begin
            fail = 1'b1;
          end else begin
            phase_next = PH_CHI;
          end
        end
        PH_CLO: begin
          if (hv_u[4] || dbyte[7:6] != 2'b10) begin
            fail = 1'b1;
          end else begin
            accum_next     = cont_acc;
            remaining_next = rem_dec;
            if (rem_dec != 2'd0) begin
              if (s1_last) begin
                fail = 1'b1;
              end else begin
                phase_next = PH_PCT;
              end
            end else if (cont_acc > MaxCp || (cont_acc >= SurLo && cont_acc <= SurHi) ||
                         (seq_len == 2'd2 && cont_acc < MinThree) ||
                         (seq_len == 2'd3 && cont_acc < SuppBase)) begin
              fail = 1'b1;
            end else begin
              if (cont_acc >= SuppBase) begin
                units[0] = {HiSurTag, supp[19:10]};
                units[1] = {LoSurTag, supp[9:0]};
                n_units  = CntW'(2);
              end else begin
                units[0] = cont_acc[15:0];
                n_units  = CntW'(1);
              end
              phase_next = PH_IDLE;
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
          fail = 1'b1;
        end
      endcase
    end

    // UTF-8 bytes of the code point, each as a %XY triplet
    if (enc_go) begin
      if (enc_cp < 21'h80) begin
        unb = 3'd1;
        ubytes[0] = enc_cp[7:0];
      end else if (enc_cp < MinThree) begin
        unb = 3'd2;
        ubytes[0] = {3'b110, enc_cp[10:6]};
        ubytes[1] = {2'b10, enc_cp[5:0]};
      end else if (enc_cp < SuppBase) begin
        unb = 3'd3;
        ubytes[0] = {4'b1110, enc_cp[15:12]};
        ubytes[1] = {2'b10, enc_cp[11:6]};
        ubytes[2] = {2'b10, enc_cp[5:0]};
      end else begin
        unb = 3'd4;
        ubytes[0] = {5'b11110, enc_cp[20:18]};
        ubytes[1] = {2'b10, enc_cp[17:12]};
        ubytes[2] = {2'b10, enc_cp[11:6]};
        ubytes[3] = {2'b10, enc_cp[5:0]};
      end
      for (int k = 0; k < 4; k++) begin
        if (3'(k) < unb) begin
          units[3*k]   = ChPercent;
          units[3*k+1] = {8'h00, hex_char(ubytes[k][7:4])};
          units[3*k+2] = {8'h00, hex_char(ubytes[k][3:0])};
          n_units      = n_units + CntW'(3);
        end
      end
    end

    // build the result beats
    res_n = '0;
    if (!discarding) begin
      if (fail) begin
        res[0].se  = 1'b1;
        res[0].mal = 1'b1;
        res_n      = CntW'(1);
      end else if (n_units == '0) begin
        if (s1_last) begin
          res[0].se = 1'b1;
          res_n     = CntW'(1);
        end
      end else begin
        for (int k = 0; k < MaxUnits; k++) begin
          res[k].unit = units[k];
          res[k].uv   = CntW'(k) < n_units;
          res[k].se   = s1_last && (CntW'(k) == n_units - CntW'(1));
        end
        res_n = n_units;
      end
    end

    // end of string or fault: restart the string state
    clear_st = discarding ? s1_last : (fail || s1_last);
    if (clear_st) begin
      held_high_next    = '0;
      high_pending_next = 1'b0;
      phase_next        = PH_IDLE;
      first_hex_next    = '0;
      accum_next        = '0;
      remaining_next    = '0;
      seq_len_next      = '0;
      discarding_next   = !discarding && fail && !s1_last;
    end
  end

  // string state and mode
  always_ff @(posedge clk) begin
    if (rst || codec_mode_wr_en) begin
      held_high    <= '0;
      high_pending <= 1'b0;
      phase        <= PH_IDLE;
      first_hex    <= '0;
      accum        <= '0;
      remaining    <= '0;
      seq_len      <= '0;
      discarding   <= 1'b0;
    end else if (s1_adv) begin
      held_high    <= held_high_next;
      high_pending <= high_pending_next;
      phase        <= phase_next;
      first_hex    <= first_hex_next;
      accum        <= accum_next;
      remaining    <= remaining_next;
      seq_len      <= seq_len_next;
      discarding   <= discarding_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 2'd0;
    end else if (codec_mode_wr_en) begin
      mode <= codec_mode_wr_data;
    end
  end

  // result buffer: load a fresh list or advance one beat
  always_ff @(posedge clk) begin
    if (rst) begin
      rcnt <= '0;
    end else if (s1_adv) begin
      rcnt <= res_n;
    end else if (out_fire) begin
      rcnt <= rcnt - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int k = 0; k < MaxUnits; k++) begin
        rbuf[k] <= res[k];
      end
    end else if (out_fire) begin
      for (int k = 0; k < MaxUnits - 1; k++) begin
        rbuf[k] <= rbuf[k+1];
      end
    end
  end

  // checks
  `UPC_ASSERT(a_drain_step, clk, rst, out_fire && !s1_adv |=> rcnt == $past(rcnt) - CntW'(1), "result buffer did not advance by one beat")
  `UPC_ASSERT(a_error_beat, clk, rst, out_valid && malformed |-> string_end && !unit_valid && out_unit == 16'h0000, "malformed beat is not a bare end")
  `UPC_NEVER(a_dec_no_high, clk, rst, mode[ModeDecodeBit] && high_pending, "surrogate held while decoding")
  `UPC_ASSERT(a_empty_ready, clk, rst, !out_valid |-> in_ready, "input stalled with empty result buffer")

endmodule
